// ===== src/uar_pkg.sv =====
package uar_pkg;

    localparam int ADDR_W  = 32;
    localparam int TASK_W  = 15;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;

    localparam int POOL_ENTRIES_DEF = 256;
    localparam int HASH_BITS_DEF    = 6;

    // depth of the queue between the classifier and the chain walker
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ADDR_W-1:0] HASH_MULT = 32'h9e37_0001;

    typedef enum logic [1:0] {
        ST_IGNORED = 2'd0,
        ST_FOUND   = 2'd1,
        ST_ADDED   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [INDEX_W-1:0]   entry_index;
        logic [COUNT_W-1:0]   entry_count;
    } t_result;

endpackage

// ===== src/unique_address_recorder_unit.sv =====
// Records each distinct function-entry address seen from one target task in a
// chained hash set: 2**HASH_BITS buckets over a pool of POOL_ENTRIES slots. An
// event passes a classify/hash register, a two-entry queue, and then the chain
// walker. On a target-task event the walker reads the bucket head and then the
// chain nodes from the pool memory, one per cycle, until it finds the address or
// reaches the end of the chain; an event from any other task is reported as ignored.
// After reset the bucket table is swept clean, and full stays high during the sweep.
// Write target_task only while no transaction is in flight.
module unique_address_recorder_unit #(
    parameter int POOL_ENTRIES = uar_pkg::POOL_ENTRIES_DEF,
    parameter int HASH_BITS    = uar_pkg::HASH_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [uar_pkg::TASK_W-1:0]    i_cfg_wr_data,
    input  logic                          push,
    output logic                          full,
    input  logic [uar_pkg::ADDR_W-1:0]    i_func_address,
    input  logic [uar_pkg::TASK_W-1:0]    i_task_id,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    o_status,
    output logic [uar_pkg::INDEX_W-1:0]   o_entry_index,
    output logic [uar_pkg::COUNT_W-1:0]   o_entry_count
);
    import uar_pkg::*;

    localparam int QW = ADDR_W + HASH_BITS + 1;

    logic          clearing;
    logic          q_full;
    logic          q_push;
    logic [QW-1:0] q_wdata;
    logic          q_empty;
    logic          q_pop;
    logic [QW-1:0] q_rdata;
    t_result       result;

    uar_front #(
        .HASH_BITS (HASH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_push         (push),
        .o_full         (full),
        .i_func_address (i_func_address),
        .i_task_id      (i_task_id),
        .i_hold         (clearing),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata)
    );

    uar_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    uar_back #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .HASH_BITS    (HASH_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (q_rdata),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (result)
    );

    assign o_status      = result.status;
    assign o_entry_index = result.entry_index;
    assign o_entry_count = result.entry_count;

endmodule

// ===== src/uar_front.sv =====
module uar_front #(
    parameter int HASH_BITS = uar_pkg::HASH_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [uar_pkg::TASK_W-1:0]          i_cfg_wr_data,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [uar_pkg::ADDR_W-1:0]          i_func_address,
    input  logic [uar_pkg::TASK_W-1:0]          i_task_id,
    input  logic                                i_hold,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output logic [uar_pkg::ADDR_W+HASH_BITS:0]  o_q_data
);
    import uar_pkg::*;

    logic [TASK_W-1:0] r_target;
    logic              r_f_valid;
    logic              n_f_valid;
    logic [ADDR_W-1:0] r_f_addr;
    logic              r_f_match;
    logic [ADDR_W-1:0] prod;
    logic              accept;

    assign o_full   = i_hold || (r_f_valid && i_q_full);
    assign accept   = i_push && !o_full;
    assign o_q_push = r_f_valid && !i_q_full;

    // only the low word of the product matters; bucket is its top bits
    assign prod     = r_f_addr * HASH_MULT;
    assign o_q_data = {r_f_match, r_f_addr, prod[ADDR_W-1 -: HASH_BITS]};

    always_comb begin
        priority if (accept) begin
            n_f_valid = 1'b1;
        end else if (o_q_push) begin
            n_f_valid = 1'b0;
        end else begin
            n_f_valid = r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_f_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
            r_f_valid <= n_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_addr  <= i_func_address;
            r_f_match <= (i_task_id == r_target);
        end
    end

endmodule

// ===== src/uar_queue.sv =====
module uar_queue #(
    parameter int W = uar_pkg::ADDR_W + 1 + uar_pkg::HASH_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    import uar_pkg::*;

    localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]    r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   r_rd;
    logic [PW-1:0]   n_rd;
    logic [CNTW-1:0] r_cnt;
    logic [CNTW-1:0] n_cnt;
    logic            push_ok;
    logic            pop_ok;

    assign o_full  = (r_cnt == CNTW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({push_ok, pop_ok})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== src/uar_back.sv =====
module uar_back #(
    parameter int POOL_ENTRIES = uar_pkg::POOL_ENTRIES_DEF,
    parameter int HASH_BITS    = uar_pkg::HASH_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [uar_pkg::ADDR_W+HASH_BITS:0] i_q_data,
    input  logic                               i_q_empty,
    output logic                               o_q_pop,
    output logic                               o_clearing,
    input  logic                               i_pop,
    output logic                               o_empty,
    output uar_pkg::t_result                   o_result
);
    import uar_pkg::*;

    localparam int IW      = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CW      = $clog2(POOL_ENTRIES + 1);
    localparam int BUCKETS = 2 ** HASH_BITS;
    localparam int PWW     = ADDR_W + IW + 1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HEAD  = 5'b00100,
        S_WALK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // bucket word: {valid, head slot}; pool word: {address, end of chain, next slot}
    logic [IW:0]      bucket_mem [BUCKETS];
    logic [PWW-1:0]   pool_mem   [POOL_ENTRIES];

    t_state           r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [HASH_BITS-1:0] r_bkt, n_bkt;
    logic [HASH_BITS-1:0] r_clr_idx, n_clr_idx;
    logic [IW-1:0]    r_cur, n_cur;
    t_status          r_status, n_status;
    logic [IW-1:0]    r_slot, n_slot;
    logic [CW-1:0]    r_count, n_count;
    t_result          r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [IW:0]      r_bkt_rd;
    logic [PWW-1:0]   r_pool_rd;

    logic                 q_match;
    logic [ADDR_W-1:0]    q_addr;
    logic [HASH_BITS-1:0] q_bkt;
    logic                 bkt_we, bkt_re;
    logic [HASH_BITS-1:0] bkt_waddr, bkt_raddr;
    logic [IW:0]          bkt_wdata;
    logic                 pool_we, pool_re;
    logic [IW-1:0]        pool_waddr, pool_raddr;
    logic [PWW-1:0]       pool_wdata;
    logic                 do_insert;

    assign q_match    = i_q_data[ADDR_W+HASH_BITS];
    assign q_addr     = i_q_data[ADDR_W+HASH_BITS-1:HASH_BITS];
    assign q_bkt      = i_q_data[HASH_BITS-1:0];
    assign o_clearing = (r_state == S_CLEAR);
    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_bkt       = r_bkt;
        n_clr_idx   = r_clr_idx;
        n_cur       = r_cur;
        n_status    = r_status;
        n_slot      = r_slot;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_q_pop     = 1'b0;
        bkt_we      = 1'b0;
        bkt_waddr   = r_bkt;
        bkt_wdata   = {1'b1, r_count[IW-1:0]};
        bkt_re      = 1'b0;
        bkt_raddr   = q_bkt;
        pool_we     = 1'b0;
        pool_waddr  = r_count[IW-1:0];
        // new slot links to the old head, or ends the chain if the bucket was empty
        pool_wdata  = {r_addr, ~r_bkt_rd[IW], r_bkt_rd[IW-1:0]};
        pool_re     = 1'b0;
        pool_raddr  = r_bkt_rd[IW-1:0];
        do_insert   = 1'b0;

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_clr_idx;
                bkt_wdata = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_addr  = q_addr;
                    n_bkt   = q_bkt;
                    if (q_match) begin
                        bkt_re  = 1'b1;
                        n_state = S_HEAD;
                    end else begin
                        n_status = ST_IGNORED;
                        n_slot   = '0;
                        n_state  = S_DONE;
                    end
                end
            end
            S_HEAD: begin
                if (r_bkt_rd[IW]) begin
                    pool_re    = 1'b1;
                    pool_raddr = r_bkt_rd[IW-1:0];
                    n_cur      = r_bkt_rd[IW-1:0];
                    n_state    = S_WALK;
                end else begin
                    do_insert = 1'b1;
                end
            end
            S_WALK: begin
                if (r_pool_rd[PWW-1:IW+1] == r_addr) begin
                    n_status = ST_FOUND;
                    n_slot   = r_cur;
                    n_state  = S_DONE;
                end else if (r_pool_rd[IW]) begin
                    do_insert = 1'b1;
                end else begin
                    pool_re    = 1'b1;
                    pool_raddr = r_pool_rd[IW-1:0];
                    n_cur      = r_pool_rd[IW-1:0];
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_pop) begin
                    n_out.status      = r_status;
                    n_out.entry_index = INDEX_W'(r_slot);
                    n_out.entry_count = COUNT_W'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_insert) begin
            n_state = S_DONE;
            if (r_count == CW'(POOL_ENTRIES)) begin
                n_status = ST_FULL;
                n_slot   = '0;
            end else begin
                pool_we  = 1'b1;
                bkt_we   = 1'b1;
                n_count  = r_count + 1'b1;
                n_status = ST_ADDED;
                n_slot   = r_count[IW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_bkt    <= n_bkt;
        r_cur    <= n_cur;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            bucket_mem[bkt_waddr] <= bkt_wdata;
        end
        if (bkt_re) begin
            r_bkt_rd <= bucket_mem[bkt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pool_we) begin
            pool_mem[pool_waddr] <= pool_wdata;
        end
        if (pool_re) begin
            r_pool_rd <= pool_mem[pool_raddr];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(POOL_ENTRIES))
        else $error("entry count above pool size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> (r_state == S_DONE && r_status == ST_ADDED
                               && r_count == $past(r_count) + 1'b1))
        else $error("entry count moved without an insert");

    a_slot_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (r_status == ST_FOUND || r_status == ST_ADDED))
            |-> CW'(r_slot) < r_count)
        else $error("reported slot not in use");

    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_clr_idx != '1) |=> r_state == S_CLEAR)
        else $error("bucket clear ended early");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import uar_pkg::*;

    localparam int POOL_SLOTS    = POOL_ENTRIES_DEF;
    localparam int BUCKET_BITS   = HASH_BITS_DEF;
    localparam int BUCKET_COUNT  = 1 << BUCKET_BITS;
    localparam int PHASES        = 5;
    localparam int PHASE_EVENTS  = 80;       // target-task events per phase
    localparam int IDLE_GUARD    = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int ROW_COUNT     = 22;

    typedef enum logic {ROW_EVENT, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [ADDR_W-1:0]  addr;
        logic [TASK_W-1:0]  tid;       // task id, or the new target for a config row
        bit                 known;
        t_result            result;
    } t_directed_row;

    // 0x61c90001 is the inverse of the hash multiplier, so its small multiples
    // land in bucket 0 together with address 0 and build one long chain.
    t_directed_row directed_rows [ROW_COUNT] = '{
        '{ROW_EVENT,  32'h0000_0000, 15'h0000, 1'b1, '{ST_ADDED,   8'd0, 9'd1}},
        '{ROW_EVENT,  32'h0000_0000, 15'h0000, 1'b1, '{ST_FOUND,   8'd0, 9'd1}},
        '{ROW_EVENT,  32'hffff_ffff, 15'h0000, 1'b1, '{ST_ADDED,   8'd1, 9'd2}},
        '{ROW_EVENT,  32'h0000_0000, 15'h7fff, 1'b1, '{ST_IGNORED, 8'd0, 9'd2}},
        '{ROW_EVENT,  32'h61c9_0001, 15'h0000, 1'b1, '{ST_ADDED,   8'd2, 9'd3}},
        '{ROW_EVENT,  32'hc392_0002, 15'h0000, 1'b1, '{ST_ADDED,   8'd3, 9'd4}},
        '{ROW_EVENT,  32'h255b_0003, 15'h0000, 1'b1, '{ST_ADDED,   8'd4, 9'd5}},
        '{ROW_EVENT,  32'h0000_0000, 15'h0000, 1'b1, '{ST_FOUND,   8'd0, 9'd5}},
        '{ROW_EVENT,  32'hc392_0002, 15'h0000, 1'b1, '{ST_FOUND,   8'd3, 9'd5}},
        '{ROW_EVENT,  32'h0000_0001, 15'h0000, 1'b0, '{ST_IGNORED, 8'd0, 9'd0}},
        '{ROW_EVENT,  32'h8000_0000, 15'h0000, 1'b0, '{ST_IGNORED, 8'd0, 9'd0}},
        '{ROW_EVENT,  32'h0000_0000, 15'h0001, 1'b0, '{ST_IGNORED, 8'd0, 9'd0}},
        '{ROW_CONFIG, 32'h0000_0000, 15'h7fff, 1'b0, '{ST_IGNORED, 8'd0, 9'd0}},
        '{ROW_EVENT,  32'h0000_0000, 15'h7fff, 1'b1, '{ST_FOUND,   8'd0, 9'd7}},
        '{ROW_EVENT,  32'hffff_ffff, 15'h7fff, 1'b1, '{ST_FOUND,   8'd1, 9'd7}},
        '{ROW_EVENT,  32'h1234_5678, 15'h0000, 1'b1, '{ST_IGNORED, 8'd0, 9'd7}},
        '{ROW_EVENT,  32'h1234_5678, 15'h7fff, 1'b1, '{ST_ADDED,   8'd7, 9'd8}},
        '{ROW_EVENT,  32'h61c9_0001, 15'h4000, 1'b1, '{ST_IGNORED, 8'd0, 9'd8}},
        '{ROW_CONFIG, 32'h0000_0000, 15'h0000, 1'b0, '{ST_IGNORED, 8'd0, 9'd0}},
        '{ROW_EVENT,  32'h7fff_ffff, 15'h0000, 1'b0, '{ST_IGNORED, 8'd0, 9'd0}},
        '{ROW_EVENT,  32'haaaa_aaaa, 15'h0000, 1'b0, '{ST_IGNORED, 8'd0, 9'd0}},
        '{ROW_EVENT,  32'h5555_5555, 15'h0000, 1'b0, '{ST_IGNORED, 8'd0, 9'd0}}
    };

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_wr_en    = 1'b0;
    logic [TASK_W-1:0]   i_cfg_wr_data  = '0;
    logic                push           = 1'b0;
    logic                full;
    logic [ADDR_W-1:0]   i_func_address = '0;
    logic [TASK_W-1:0]   i_task_id      = '0;
    logic                empty;
    logic                pop            = 1'b0;
    logic [1:0]          o_status;
    logic [INDEX_W-1:0]  o_entry_index;
    logic [COUNT_W-1:0]  o_entry_count;

    unique_address_recorder_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .push           (push),
        .full           (full),
        .i_func_address (i_func_address),
        .i_task_id      (i_task_id),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_entry_index  (o_entry_index),
        .o_entry_count  (o_entry_count)
    );

    always #1 i_clk = ~i_clk;

    // shadow copy of the hash set
    logic [INDEX_W-1:0]  chain_head   [BUCKET_COUNT];
    bit                  chain_live   [BUCKET_COUNT];
    logic [ADDR_W-1:0]   slot_address [POOL_SLOTS];
    logic [COUNT_W-1:0]  slot_link    [POOL_SLOTS];
    int unsigned         slots_used    = 0;
    logic [TASK_W-1:0]   recorded_task = '0;

    t_result             pending_results [$];
    logic [ADDR_W-1:0]   seen_addresses  [$];
    int                  status_tally [4] = '{0, 0, 0, 0};
    int                  events_sent     = 0;
    int                  config_writes   = 0;
    int                  results_checked = 0;
    int                  mismatch_count  = 0;
    int                  burst_left      = 0;
    bit                  steady_stream   = 1'b0;
    logic                hold_req        = 1'b0;
    int                  cycle_count     = 0;

    function automatic t_result record_event(input logic [ADDR_W-1:0] addr,
                                             input logic [TASK_W-1:0] tid);
        logic [ADDR_W-1:0] product;
        int                bucket;
        int                cur;
        int                steps;
        bit                hit;
        t_result           r;
        r.status      = ST_IGNORED;
        r.entry_index = '0;
        if (tid == recorded_task) begin
            product = addr * HASH_MULT;
            bucket  = int'(product[ADDR_W-1 -: BUCKET_BITS]);
            hit     = 1'b0;
            cur     = int'(chain_head[bucket]);
            steps   = 0;
            while (chain_live[bucket] && !hit && steps < POOL_SLOTS && cur < POOL_SLOTS) begin
                if (slot_address[cur] == addr) begin
                    hit           = 1'b1;
                    r.entry_index = cur[INDEX_W-1:0];
                end else begin
                    cur = int'(slot_link[cur]);
                    steps++;
                end
            end
            if (hit) begin
                r.status = ST_FOUND;
            end else if (slots_used >= POOL_SLOTS) begin
                r.status = ST_FULL;
            end else begin
                slot_address[slots_used] = addr;
                // a link of POOL_SLOTS ends the chain
                slot_link[slots_used] = chain_live[bucket] ? {1'b0, chain_head[bucket]}
                                                           : COUNT_W'(POOL_SLOTS);
                chain_head[bucket] = slots_used[INDEX_W-1:0];
                chain_live[bucket] = 1'b1;
                r.entry_index      = slots_used[INDEX_W-1:0];
                r.status           = ST_ADDED;
                slots_used++;
            end
        end
        r.entry_count = slots_used[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch on transaction %0d: %s got 0x%0h, want 0x%0h",
                     results_checked, what, got, want);
    endtask

    // sender idles before some bursts of random length, but never in steady-stream mode
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = 0;
            if (!steady_stream && $urandom_range(3) != 0)
                gap = $urandom_range(1, 10);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic offer_event(input logic [ADDR_W-1:0] addr, input logic [TASK_W-1:0] tid,
                               input bit known, input t_result known_result);
        t_result predicted;
        pace();
        push           <= 1'b1;
        i_func_address <= addr;
        i_task_id      <= tid;
        do @(posedge i_clk); while (full !== 1'b0);
        predicted = record_event(addr, tid);
        status_tally[predicted.status]++;
        events_sent++;
        pending_results.push_back(known ? known_result : predicted);
    endtask

    task automatic drain_and_configure(input logic [TASK_W-1:0] value);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        recorded_task = value;
        config_writes++;
    endtask

    // receiver: rotating stall pattern, re-rolled now and then, plus one long hold
    initial begin : receiver
        logic [31:0] stall_pattern;
        int          pattern_age;
        int          hold_left;
        bit          hold_done;
        t_result     want;
        stall_pattern = '1;
        pattern_age   = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && empty === 1'b0) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("transaction with nothing pending, status",
                                    32'(o_status), 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    if (o_entry_index !== want.entry_index)
                        report_mismatch("entry_index", 32'(o_entry_index),
                                        32'(want.entry_index));
                    if (o_entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(o_entry_count),
                                        32'(want.entry_count));
                end
                results_checked++;
            end
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                if (pattern_age == 0) begin
                    case ($urandom_range(3))
                        0:       stall_pattern = '1;
                        1:       stall_pattern = $urandom;
                        2:       stall_pattern = $urandom | $urandom;
                        default: stall_pattern = $urandom & $urandom;
                    endcase
                    pattern_age = 48;
                end
                pattern_age--;
                pop <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        logic [TASK_W-1:0] target;
        logic [TASK_W-1:0] offset;
        logic [ADDR_W-1:0] addr;
        int                target_done;
        int                roll;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG)
                drain_and_configure(directed_rows[i].tid);
            else
                offer_event(directed_rows[i].addr, directed_rows[i].tid,
                            directed_rows[i].known, directed_rows[i].result);
        end

        // mostly target-task events: fresh addresses fill the pool, repeats walk chains
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       target = '1;
                2:       target = '0;
                4:       target = 15'd1;
                default: target = TASK_W'($urandom_range(1, 32766));
            endcase
            drain_and_configure(target);
            steady_stream = (phase == 3);
            target_done   = 0;
            while (target_done < PHASE_EVENTS) begin
                if (phase == 1 && target_done == 30)
                    hold_req <= 1'b1;
                roll = $urandom_range(99);
                if (seen_addresses.size() != 0 && roll >= 75)
                    addr = seen_addresses[$urandom_range(seen_addresses.size() - 1)];
                else
                    addr = $urandom;
                if (roll < 18) begin
                    offset = TASK_W'($urandom_range(1, 32767));
                    offer_event(addr, recorded_task ^ offset, 1'b0, '0);
                end else begin
                    if (roll < 75)
                        seen_addresses.push_back(addr);
                    offer_event(addr, recorded_task, 1'b0, '0);
                    target_done++;
                end
            end
        end

        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d events across %0d target-task settings, pool filled to %0d.",
                 events_sent, config_writes, slots_used);
        $display("Outcomes: %0d added, %0d found, %0d pool full, %0d other task.",
                 status_tally[ST_ADDED], status_tally[ST_FOUND], status_tally[ST_FULL],
                 status_tally[ST_IGNORED]);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
